// ===== sv/double_ended_queue_defines.svh =====
// assertion macros for the double-ended queue
// clk and rst_n are taken from the scope of the use
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DQ_ASSERT_IMPL(label, ante, cons, msg)
`define DQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== sv/dq_pkg.sv =====
package dq_pkg;

  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } dq_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } dq_status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_up;    // every word moves one cell toward the rear
    logic shift_down;  // every word moves one cell toward the front
    logic load_tail;   // the cell at the tail position takes the new word
  } dq_cell_ctl_t;

endpackage

// ===== sv/dq_if.sv =====
interface dq_in_if;
  logic                               valid;
  logic                               ready;
  logic        [dq_pkg::OPCODE_W-1:0] opcode;
  logic signed [dq_pkg::VALUE_W-1:0]  push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface dq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dq_pkg::VALUE_W-1:0]  popped_value;
  logic        [dq_pkg::STATUS_W-1:0] status;
  logic        [dq_pkg::COUNT_W-1:0]  entry_count;
  logic                               is_empty;

  modport source (output valid, output popped_value, output status,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input popped_value, input status,
                  input entry_count, input is_empty, output ready);
endinterface

// ===== sv/dq_cell.sv =====
module dq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int IDX        = 0
) (
  input  logic                 clk,
  input  dq_pkg::dq_cell_ctl_t ctl,
  input  logic [DATA_WIDTH-1:0] load_word,
  input  logic [IDX_W-1:0]     tail_pos,
  input  logic [IDX_W-1:0]     rear_pos,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  input  logic [DATA_WIDTH-1:0] right_ret,
  output logic [DATA_WIDTH-1:0] word,
  output logic [DATA_WIDTH-1:0] ret
);

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(IDX);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] ret_r;

  always_ff @(posedge clk) begin
    priority if (ctl.shift_up) begin
      word_r <= left_word;
    end else if (ctl.shift_down) begin
      word_r <= right_word;
    end else if (ctl.load_tail && (tail_pos == MY_POS)) begin
      word_r <= load_word;
    end else begin
      // hold
      word_r <= word_r;
    end
    // return path: the rear cell injects its word, others pass toward the front
    ret_r <= (rear_pos == MY_POS) ? word_r : right_ret;
  end

  assign word = word_r;
  assign ret  = ret_r;

endmodule

// ===== sv/dq_ctrl.sv =====
`include "double_ended_queue_defines.svh"

module dq_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dq_in_if.sink                 in_ch,
  dq_out_if.source              out_ch,
  output dq_pkg::dq_cell_ctl_t  cell_ctl,
  output logic [DATA_WIDTH-1:0] load_word,
  output logic [$clog2(DEPTH)-1:0] tail_pos,
  output logic [$clog2(DEPTH)-1:0] rear_pos,
  input  logic [DATA_WIDTH-1:0] front_word,
  input  logic [DATA_WIDTH-1:0] rear_word
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_t;

  state_t                              state_r;
  logic [CNT_W-1:0]                    count_r;
  logic [CNT_W-1:0]                    wait_r;
  logic                                out_valid_r;
  logic signed [dq_pkg::VALUE_W-1:0]   popped_r;
  logic [dq_pkg::STATUS_W-1:0]         status_r;
  logic [dq_pkg::COUNT_W-1:0]          ecount_r;
  logic                                empty_r;

  logic             in_ready;
  logic             accept;
  logic             full;
  logic             empty;
  logic             out_load;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_dec;
  dq_pkg::dq_op_t   op;

  function automatic logic [dq_pkg::VALUE_W-1:0] to_result(logic [DATA_WIDTH-1:0] w);
    logic signed [DATA_WIDTH-1:0] s;
    logic signed [63:0]           x;
    s = signed'(w);
    x = 64'(s);
    return x[dq_pkg::VALUE_W-1:0];
  endfunction

  assign in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;
  assign op          = dq_pkg::dq_op_t'(in_ch.opcode);
  assign full        = (count_r == FULL_CNT);
  assign empty       = (count_r == '0);
  assign count_inc   = count_r + ONE_CNT;
  assign count_dec   = count_r - ONE_CNT;

  // a result item is loaded on every accept except a rear pop that must walk,
  // and at the end of that walk
  assign out_load = (state_r == S_IDLE)
                    ? (accept && !((op == dq_pkg::OP_POP_REAR) && !empty))
                    : ((wait_r == '0) && (!out_valid_r || out_ch.ready));

  assign load_word = DATA_WIDTH'(in_ch.push_value);
  assign tail_pos  = count_r[IDX_W-1:0];
  assign rear_pos  = count_dec[IDX_W-1:0];

  always_comb begin
    cell_ctl = '0;
    if (accept) begin
      unique case (op)
        dq_pkg::OP_PUSH_FRONT: cell_ctl.shift_up   = !full;
        dq_pkg::OP_PUSH_REAR:  cell_ctl.load_tail  = !full;
        dq_pkg::OP_POP_FRONT:  cell_ctl.shift_down = !empty;
        dq_pkg::OP_POP_REAR:   cell_ctl = '0;
        default:               cell_ctl = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (op)
              dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
                popped_r    <= '0;
                empty_r     <= 1'b0;
                if (full) begin
                  status_r <= dq_pkg::ST_OVERFLOW;
                  ecount_r <= dq_pkg::COUNT_W'(count_r);
                end else begin
                  count_r  <= count_inc;
                  status_r <= dq_pkg::ST_OK;
                  ecount_r <= dq_pkg::COUNT_W'(count_inc);
                end
              end
              dq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                  popped_r <= '1;
                  status_r <= dq_pkg::ST_UNDERFLOW;
                  ecount_r <= '0;
                  empty_r  <= 1'b1;
                end else begin
                  count_r  <= count_dec;
                  popped_r <= to_result(front_word);
                  status_r <= dq_pkg::ST_OK;
                  ecount_r <= dq_pkg::COUNT_W'(count_dec);
                  empty_r  <= (count_dec == '0);
                end
              end
              dq_pkg::OP_POP_REAR: begin
                if (empty) begin
                  popped_r    <= '1;
                  status_r    <= dq_pkg::ST_UNDERFLOW;
                  ecount_r    <= '0;
                  empty_r     <= 1'b1;
                end else begin
                  // let the return chain carry the rear word down to cell 0
                  state_r <= S_WAIT;
                  wait_r  <= count_r;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_WAIT: begin
          if (wait_r != '0) begin
            wait_r <= wait_r - ONE_CNT;
          end else if (!out_valid_r || out_ch.ready) begin
            popped_r    <= to_result(rear_word);
            status_r    <= dq_pkg::ST_OK;
            ecount_r    <= dq_pkg::COUNT_W'(count_dec);
            empty_r     <= (count_dec == '0);
            count_r     <= count_dec;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.status       = status_r;
  assign out_ch.entry_count  = ecount_r;
  assign out_ch.is_empty     = empty_r;

  `DQ_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= FULL_CNT, "word count above depth")
  `DQ_ASSERT_NEXT(a_push_count, accept && !full && (op == dq_pkg::OP_PUSH_FRONT || op == dq_pkg::OP_PUSH_REAR), count_r == $past(count_r) + ONE_CNT, "push did not grow count")
  `DQ_ASSERT_NEXT(a_rear_wait, accept && !empty && (op == dq_pkg::OP_POP_REAR), state_r == S_WAIT && !out_valid_r, "rear pop did not start walk")
  `DQ_ASSERT_IMPL(a_underflow, out_valid_r && (status_r == dq_pkg::ST_UNDERFLOW), popped_r == -32'sd1 && empty_r && (ecount_r == '0), "bad underflow item")

endmodule

// ===== sv/double_ended_queue.sv =====
// double-ended queue of signed DATA_WIDTH-bit words held in a chain of DEPTH
// cells, front word in cell 0 and the rest packed behind it; push front and
// pop front shift the whole chain by one cell, push rear loads the cell at the
// tail, and a return chain of registers walks the rear word toward cell 0 one
// cell per cycle; push front, push rear and pop front have their result item
// registered on the accepting edge, while pop rear puts its result item out
// only once the wait counter, loaded with the count of words stored before
// the pop, has run down, and takes no new item before, because of that walk;
// an empty pop gives -1 with underflow status, a full push is refused with
// overflow status, and ready stays high while a finished item waits only if
// it is taken in the same cycle
module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);

  localparam int IDX_W = $clog2(DEPTH);

  // command and operands broadcast from the controller to every cell
  dq_pkg::dq_cell_ctl_t  cell_ctl;
  logic [DATA_WIDTH-1:0] load_word;
  logic [IDX_W-1:0]      tail_pos;
  logic [IDX_W-1:0]      rear_pos;

  // per-cell stored word and return path
  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  logic [DATA_WIDTH-1:0] cell_ret  [DEPTH];

  // sequencer: handshakes, word count, result register, rear-pop wait
  dq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cell_ctl   (cell_ctl),
    .load_word  (load_word),
    .tail_pos   (tail_pos),
    .rear_pos   (rear_pos),
    .front_word (cell_word[0]),
    .rear_word  (cell_ret[0])
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_word;
    logic [DATA_WIDTH-1:0] right_word;
    logic [DATA_WIDTH-1:0] right_ret;

    // cell 0 takes the pushed word on a front shift
    if (i == 0) begin : g_first
      assign left_word = load_word;
    end else begin : g_mid_left
      assign left_word = cell_word[i-1];
    end

    // the last cell keeps its own word on a down shift and feeds its own return
    if (i == DEPTH - 1) begin : g_last
      assign right_word = cell_word[i];
      assign right_ret  = cell_ret[i];
    end else begin : g_mid_right
      assign right_word = cell_word[i+1];
      assign right_ret  = cell_ret[i+1];
    end

    dq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .load_word  (load_word),
      .tail_pos   (tail_pos),
      .rear_pos   (rear_pos),
      .left_word  (left_word),
      .right_word (right_word),
      .right_ret  (right_ret),
      .word       (cell_word[i]),
      .ret        (cell_ret[i])
    );
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 16;
  // a pop from the rear walks the word down the chain before its result comes out
  localparam int SETTLE_CYCLES = 3 * (DEPTH + 1);

  // one result item as the block should produce it
  typedef struct {
    logic signed [dq_pkg::VALUE_W-1:0]  popped_value;
    dq_pkg::dq_status_t                 status;
    logic        [dq_pkg::COUNT_W-1:0]  entry_count;
    logic                               is_empty;
  } dq_result_t;

  logic clk = 1'b0;
  logic rst_n;

  dq_in_if  in_ch ();
  dq_out_if out_ch ();

  double_ended_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (dq_pkg::VALUE_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the deque: ring, front position and word count
  logic signed [dq_pkg::VALUE_W-1:0] shadow_ring [DEPTH];
  logic        [3:0]                 shadow_head;
  logic        [dq_pkg::COUNT_W-1:0] shadow_count;

  dq_result_t pending_results [$];

  int error_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver back-pressure, changed at the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // apply one operation to the shadow deque and return the result it gives
  function automatic dq_result_t apply_deque_op(input dq_pkg::dq_op_t op,
                                                input logic signed [dq_pkg::VALUE_W-1:0] word);
    dq_result_t res;
    logic [3:0] rear_pos;
    res.popped_value = '0;
    res.status       = dq_pkg::ST_OK;
    case (op)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_REAR: begin
        if (shadow_count >= dq_pkg::COUNT_W'(DEPTH)) begin
          // full: word is dropped, nothing moves
          res.status = dq_pkg::ST_OVERFLOW;
        end else if (op == dq_pkg::OP_PUSH_FRONT) begin
          shadow_head = shadow_head - 4'd1;
          shadow_ring[shadow_head] = word;
          shadow_count++;
        end else begin
          rear_pos = shadow_head + shadow_count[3:0];
          shadow_ring[rear_pos] = word;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == '0) begin
          // empty: all ones with underflow, state untouched
          res.status       = dq_pkg::ST_UNDERFLOW;
          res.popped_value = -1;
        end else if (op == dq_pkg::OP_POP_FRONT) begin
          res.popped_value = shadow_ring[shadow_head];
          shadow_head = shadow_head + 4'd1;
          shadow_count--;
        end else begin
          // a pop from the rear leaves the head where it is
          rear_pos = shadow_head + shadow_count[3:0] - 4'd1;
          res.popped_value = shadow_ring[rear_pos];
          shadow_count--;
        end
      end
    endcase
    res.entry_count = shadow_count;
    res.is_empty    = (shadow_count == '0);
    return res;
  endfunction

  // present one item at the falling edge, hold it until it is taken
  task automatic send_item(input dq_pkg::dq_op_t op,
                           input logic signed [dq_pkg::VALUE_W-1:0] word);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.push_value <= word;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(apply_deque_op(op, word));
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    dq_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_ch.popped_value !== want.popped_value)
          report_mismatch($sformatf("popped_value got %0d want %0d",
                                    out_ch.popped_value, want.popped_value));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_ch.status, want.status));
        if (out_ch.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    out_ch.entry_count, want.entry_count));
        if (out_ch.is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty got %0b want %0b",
                                    out_ch.is_empty, want.is_empty));
      end
    end
  end

  // random word, leaning on the extremes now and then
  function automatic logic signed [dq_pkg::VALUE_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // pops on an empty deque, front and rear
  task automatic test_empty_pops();
    send_item(dq_pkg::OP_POP_FRONT, 32'sh12345678);
    send_item(dq_pkg::OP_POP_REAR, -1);
  endtask

  // one word in and out each way, the emptying pop included
  task automatic test_single_word();
    send_item(dq_pkg::OP_PUSH_FRONT, 32'sh7fffffff);
    send_item(dq_pkg::OP_POP_REAR, '0);
    send_item(dq_pkg::OP_PUSH_REAR, 32'sh80000000);
    send_item(dq_pkg::OP_POP_FRONT, '0);
  endtask

  // fill from both ends, then push on a full deque from both ends
  task automatic test_fill_and_overflow();
    logic signed [dq_pkg::VALUE_W-1:0] fill_words [4];
    fill_words[0] = 32'sh7fffffff;
    fill_words[1] = 32'sh80000000;
    fill_words[2] = 32'shaaaaaaaa;
    fill_words[3] = 32'sh55555555;
    for (int i = 0; i < DEPTH; i++) begin
      send_item((i % 2 == 0) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_REAR,
                fill_words[i % 4]);
    end
    send_item(dq_pkg::OP_PUSH_FRONT, -1);
    send_item(dq_pkg::OP_PUSH_REAR, '0);
  endtask

  // random walk whose push/pop bias flips now and then, so that the deque
  // swings between full and empty; halfway the sender waits for every result
  task automatic test_random_mix(input int num_items);
    int             push_pct;
    int             run_left;
    dq_pkg::dq_op_t op;
    push_pct = 50;
    run_left = 0;
    for (int i = 0; i < num_items; i++) begin
      if (run_left == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
        run_left = $urandom_range(60, 10);
      end
      run_left--;
      if ($urandom_range(99) < push_pct)
        op = ($urandom_range(1) == 0) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_REAR;
      else
        op = ($urandom_range(1) == 0) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_REAR;
      send_item(op, pick_word());
      if (i == num_items / 2)
        wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin
    // every input known from time zero
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = dq_pkg::OP_PUSH_FRONT;
    in_ch.push_value = '0;
    out_ch.ready     = 1'b0;
    shadow_head      = '0;
    shadow_count     = '0;
    for (int i = 0; i < DEPTH; i++) shadow_ring[i] = '0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 7;
    recv_idle_pct = 86;
    test_empty_pops();
    test_single_word();
    test_fill_and_overflow();
    test_random_mix(460);

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 86;
    recv_idle_pct = 7;
    test_random_mix(460);

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(460);

    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
